@@ design/apsp_pkg.sv @@
`default_nettype none
package apsp_pkg;
    localparam int unsigned DIST_W = 17;
    localparam logic [DIST_W-1:0] INF_DIST = 17'd100000;
    typedef logic [DIST_W-1:0] dist_t;

    // Saturated sum: anything at or above infinity reads as infinity.
    function automatic dist_t sat_add(input dist_t a, input dist_t b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, INF_DIST}) begin
            sat_add = INF_DIST;
        end else begin
            sat_add = s[DIST_W-1:0];
        end
    endfunction
endpackage
`default_nettype wire

@@ design/apsp_cell.sv @@
`default_nettype none
// One matrix row. Each cycle it may clear to its initial row, load an edge weight,
// relax one entry against the broadcast pivot row, or shift its contents one column
// left so that the row streams out at the cell's left end.
module apsp_cell #(
    parameter int unsigned MAX_NODES = 8,
    parameter int unsigned IDX_W = 3
) (
    input  wire logic                   aclk,
    input  wire logic                   clr,
    input  wire logic [IDX_W-1:0]       row_id,
    input  wire logic                   wr_en,
    input  wire logic [IDX_W-1:0]       wr_col,
    input  wire apsp_pkg::dist_t        wr_data,
    input  wire logic                   relax_en,
    input  wire logic [IDX_W-1:0]       k_idx,
    input  wire logic [IDX_W-1:0]       j_idx,
    input  wire apsp_pkg::dist_t        pivot_d,
    input  wire logic                   shift_en,
    input  wire apsp_pkg::dist_t        shift_in,
    output apsp_pkg::dist_t             head_d,
    output apsp_pkg::dist_t             sel_d
);
    apsp_pkg::dist_t row_reg [MAX_NODES];
    apsp_pkg::dist_t via;

    assign head_d = row_reg[0];
    assign sel_d  = row_reg[j_idx];
    assign via    = apsp_pkg::sat_add(row_reg[k_idx], pivot_d);

    // Row storage update.
    always_ff @(posedge aclk) begin
        for (int c = 0; c < MAX_NODES; c++) begin
            if (clr) begin
                row_reg[c] <= (c[IDX_W-1:0] == row_id) ? '0 : apsp_pkg::INF_DIST;
            end else if (shift_en) begin
                row_reg[c] <= (c == MAX_NODES - 1) ? shift_in : row_reg[(c + 1) % MAX_NODES];
            end else if (wr_en && wr_col == c[IDX_W-1:0]) begin
                row_reg[c] <= wr_data;
            end else if (relax_en && j_idx == c[IDX_W-1:0] && via < row_reg[c]) begin
                row_reg[c] <= via;
            end
        end
    end
endmodule
`default_nettype wire

@@ design/all_pairs_shortest_path.sv @@
`default_nettype none
// Channel  Dir  Handshake              Fields
// s_       in   s_valid / s_ready      from_vertex, to_vertex, edge_weight, last_edge
// m_       out  m_valid / m_ready      row_vertex, col_vertex, distance, unreachable,
//                                      last_result
// cfg      in   cfg_valid / cfg_ready  cfg_data (vertex_count)
// Edge items are taken one per cycle while the block is loading.
// After an item marked last, s_ready stays low through the relaxation phase (one column
// of every active row per cycle, pivot k outer), the output of N*N results and the drain
// and clear states that restore the matrix, N being the active vertex count.
// A result that waits with m_ready low stalls the output phase.
// After reset a clearing state runs before the first item is taken.
module all_pairs_shortest_path #(
    parameter int unsigned MAX_NODES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_from_vertex,
    input  wire logic [2:0]  s_to_vertex,
    input  wire logic [16:0] s_edge_weight,
    input  wire logic        s_last_edge,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_row_vertex,
    output logic [2:0]       m_col_vertex,
    output logic [16:0]      m_distance,
    output logic             m_unreachable,
    output logic             m_last_result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data
);
    localparam int unsigned IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    typedef enum logic [2:0] {ST_CLEAR, ST_LOAD, ST_RELAX, ST_OUT, ST_DRAIN} state_t;

    state_t            state_reg;
    logic [3:0]        vcount_reg;
    logic [IDX_W-1:0]  n1_reg;
    logic [IDX_W-1:0]  k_reg, j_reg, r_reg, c_reg;
    logic              mv_reg;
    logic [2:0]        mrow_reg, mcol_reg;
    apsp_pkg::dist_t   mdist_reg;
    logic              mlast_reg;

    apsp_pkg::dist_t   head_d [MAX_NODES];
    apsp_pkg::dist_t   sel_d  [MAX_NODES];
    apsp_pkg::dist_t   pivot_d, w_sat, out_d;
    logic              edge_ok, take_in, out_free, shift_en, clr, relax_en;
    logic [3:0]        n_eff;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_LOAD);
    assign take_in   = s_valid && s_ready;
    assign out_free  = !mv_reg || m_ready;
    assign clr       = (state_reg == ST_CLEAR);
    assign relax_en  = (state_reg == ST_RELAX);
    assign shift_en  = (state_reg == ST_OUT) && out_free;

    // Edge saturation and acceptance.
    assign w_sat   = (s_edge_weight > apsp_pkg::INF_DIST) ? apsp_pkg::INF_DIST : s_edge_weight;
    assign edge_ok = take_in && (32'(s_from_vertex) < MAX_NODES) &&
                     (32'(s_to_vertex) < MAX_NODES) && (s_from_vertex != s_to_vertex);
    assign n_eff   = (vcount_reg == 4'd0) ? 4'd1 :
                     ((32'(vcount_reg) > MAX_NODES) ? 4'(MAX_NODES) : vcount_reg);

    // Pivot row entry d[k][j] is broadcast to all cells; during output row r streams.
    assign pivot_d = sel_d[k_reg];
    assign out_d   = head_d[r_reg];

    // Row of cells; during output the streamed row rotates back into itself.
    for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
        logic wr;
        logic [IDX_W-1:0] wc;
        assign wr = edge_ok && (s_from_vertex[IDX_W-1:0] == g[IDX_W-1:0] ||
                                s_to_vertex[IDX_W-1:0] == g[IDX_W-1:0]);
        assign wc = (s_from_vertex[IDX_W-1:0] == g[IDX_W-1:0]) ?
                    s_to_vertex[IDX_W-1:0] : s_from_vertex[IDX_W-1:0];
        apsp_cell #(.MAX_NODES(MAX_NODES), .IDX_W(IDX_W)) u_cell (
            .aclk(aclk), .clr(clr), .row_id(g[IDX_W-1:0]),
            .wr_en(wr), .wr_col(wc), .wr_data(w_sat),
            .relax_en(relax_en && (32'(g) <= 32'(n1_reg))),
            .k_idx(k_reg), .j_idx(j_reg), .pivot_d(pivot_d),
            .shift_en(shift_en && r_reg == g[IDX_W-1:0]), .shift_in(head_d[g]),
            .head_d(head_d[g]), .sel_d(sel_d[g])
        );
    end

    // Control sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            vcount_reg <= 4'd7;
            mv_reg     <= 1'b0;
            k_reg <= '0; j_reg <= '0; r_reg <= '0; c_reg <= '0; n1_reg <= '0;
        end else begin
            if (cfg_valid) begin
                vcount_reg <= cfg_data;
            end
            // Outside the output phase a taken item simply leaves the register.
            if (mv_reg && m_ready && state_reg != ST_OUT) begin
                mv_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: state_reg <= ST_LOAD;
                ST_LOAD: begin
                    if (take_in && s_last_edge) begin
                        n1_reg    <= IDX_W'(n_eff - 4'd1);
                        k_reg <= '0; j_reg <= '0;
                        state_reg <= ST_RELAX;
                    end
                end
                ST_RELAX: begin
                    // One column j of all active rows per cycle, pivot k outer.
                    if (j_reg == n1_reg) begin
                        j_reg <= '0;
                        if (k_reg == n1_reg) begin
                            r_reg <= '0; c_reg <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end else begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        mv_reg    <= 1'b1;
                        mrow_reg  <= 3'(r_reg);
                        mcol_reg  <= 3'(c_reg);
                        mdist_reg <= out_d;
                        mlast_reg <= (r_reg == n1_reg) && (c_reg == n1_reg);
                        if (c_reg == n1_reg) begin
                            c_reg <= '0;
                            if (r_reg == n1_reg) begin
                                state_reg <= ST_DRAIN;
                            end else begin
                                r_reg <= r_reg + 1'b1;
                            end
                        end else begin
                            c_reg <= c_reg + 1'b1;
                        end
                    end
                end
                ST_DRAIN: state_reg <= ST_CLEAR;
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    assign m_valid       = mv_reg;
    assign m_row_vertex  = mrow_reg;
    assign m_col_vertex  = mcol_reg;
    assign m_distance    = mdist_reg;
    assign m_unreachable = (mdist_reg == apsp_pkg::INF_DIST);
    assign m_last_result = mlast_reg;
endmodule
`default_nettype wire

@@ tb/all_pairs_shortest_path_test.sv @@
module all_pairs_shortest_path_test;

    localparam int NODES = 8;
    localparam int CYCLE_LIMIT = 2000000;

    // One row of the directed table; check_exp selects a typed-in expectation.
    typedef struct {
        logic [2:0]  from_v;
        logic [2:0]  to_v;
        logic [16:0] weight;
        logic        last;
        bit          check_exp;
        logic [16:0] exp_d01;
    } edge_row_t;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [16:0] dist_val;
        logic        unreach;
        logic        last;
    } dist_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_from_vertex;
    logic [2:0]  s_to_vertex;
    logic [16:0] s_edge_weight;
    logic        s_last_edge;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_row_vertex;
    logic [2:0]  m_col_vertex;
    logic [16:0] m_distance;
    logic        m_unreachable;
    logic        m_last_result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    all_pairs_shortest_path dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_from_vertex(s_from_vertex), .s_to_vertex(s_to_vertex),
        .s_edge_weight(s_edge_weight), .s_last_edge(s_last_edge),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_row_vertex(m_row_vertex), .m_col_vertex(m_col_vertex),
        .m_distance(m_distance), .m_unreachable(m_unreachable),
        .m_last_result(m_last_result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Predictor state: the distance matrix and the vertex count register.
    logic [16:0] dist_mat [NODES][NODES];
    logic [3:0]  vcount_reg;
    dist_item_t  expected_dists [$];
    int          fail_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    logic [16:0] dut_d01_seen;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Timeout watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL all_pairs_shortest_path");
            $finish;
        end
    end

    function automatic void clear_distances();
        for (int r = 0; r < NODES; r++)
            for (int c = 0; c < NODES; c++)
                dist_mat[r][c] = (r == c) ? 17'd0 : apsp_pkg::INF_DIST;
    endfunction

    // Stores one edge and, on the last one, solves and queues the distances.
    function automatic void predict_edge(logic [2:0] a, logic [2:0] b, logic [16:0] w,
                                         logic last);
        int n;
        logic [17:0] via;
        dist_item_t it;
        if (w > apsp_pkg::INF_DIST) w = apsp_pkg::INF_DIST;
        if (a != b) begin
            dist_mat[a][b] = w;
            dist_mat[b][a] = w;
        end
        if (!last) return;
        n = (vcount_reg == 0) ? 1 : (vcount_reg > NODES) ? NODES : vcount_reg;
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    via = dist_mat[i][k] + dist_mat[k][j];
                    if (dist_mat[i][j] > via) dist_mat[i][j] = via[16:0];
                end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                it.row = 3'(i);
                it.col = 3'(j);
                it.dist_val = dist_mat[i][j];
                it.unreach = (dist_mat[i][j] == apsp_pkg::INF_DIST);
                it.last = (i == n - 1 && j == n - 1);
                expected_dists.push_back(it);
            end
        clear_distances();
    endfunction

    // Result side: random stalls, plus a long hold-off when asked.
    always @(posedge aclk) begin
        if (!aresetn || hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted distance with the oldest expectation.
    always @(posedge aclk) begin
        dist_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_dists.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d dist %0d",
                         $time, m_row_vertex, m_col_vertex, m_distance);
                fail_count++;
            end else begin
                e = expected_dists.pop_front();
                if (m_row_vertex !== e.row) begin
                    $display("%0t: row_vertex expected %0d actual %0d",
                             $time, e.row, m_row_vertex);
                    fail_count++;
                end
                if (m_col_vertex !== e.col) begin
                    $display("%0t: col_vertex expected %0d actual %0d",
                             $time, e.col, m_col_vertex);
                    fail_count++;
                end
                if (m_distance !== e.dist_val) begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, e.dist_val, m_distance);
                    fail_count++;
                end
                if (m_unreachable !== e.unreach) begin
                    $display("%0t: unreachable expected %0d actual %0d",
                             $time, e.unreach, m_unreachable);
                    fail_count++;
                end
                if (m_last_result !== e.last) begin
                    $display("%0t: last_result expected %0d actual %0d",
                             $time, e.last, m_last_result);
                    fail_count++;
                end
            end
        end
    end

    // Captures the (0,1) distance of each solved matrix for the typed-in checks.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready && m_row_vertex == 3'd0 && m_col_vertex == 3'd1)
            dut_d01_seen <= m_distance;
    end

    // Offers one edge item and waits until it is accepted; valid stays high after.
    task automatic send_edge(logic [2:0] a, logic [2:0] b, logic [16:0] w, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_from_vertex <= a;
        s_to_vertex <= b;
        s_edge_weight <= w;
        s_last_edge <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_edge(a, b, w, last);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_dists.size() != 0) @(posedge aclk);
        repeat (700) @(posedge aclk);
    endtask

    task automatic write_vertex_count(logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        vcount_reg = v;
    endtask

    // Mostly well-formed graphs over vertex numbers 0 to 7, with some noise.
    task automatic send_random_graph(int edges);
        logic [2:0]  a;
        logic [2:0]  b;
        logic [16:0] w;
        int          sel;
        for (int e = 0; e < edges; e++) begin
            a = 3'($urandom_range(7));
            b = 3'($urandom_range(7));
            sel = $urandom_range(99);
            if (sel < 60) w = 17'($urandom_range(60));
            else if (sel < 80) w = 17'($urandom_range(100000));
            else if (sel < 88) w = apsp_pkg::INF_DIST;
            else w = 17'($urandom_range(17'h1FFFF));
            send_edge(a, b, w, e == edges - 1);
        end
    endtask

    initial begin
        edge_row_t rows [$];
        edge_row_t r;
        int phase_idle [4];
        int phase_stall [4];
        logic [3:0] vc_list [6];

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_from_vertex = '0;
        s_to_vertex = '0;
        s_edge_weight = '0;
        s_last_edge = 1'b0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        vcount_reg = 4'd7;
        clear_distances();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset vertex count: extremes and the special cases.
        rows = '{
            '{3'd0, 3'd1, 17'd0,      1'b0, 1'b0, 17'd0},
            '{3'd1, 3'd2, 17'd5,      1'b0, 1'b0, 17'd0},
            '{3'd2, 3'd2, 17'd9,      1'b0, 1'b0, 17'd0},
            '{3'd0, 3'd1, 17'd7,      1'b0, 1'b0, 17'd0},
            '{3'd3, 3'd4, 17'h1FFFF,  1'b0, 1'b0, 17'd0},
            '{3'd4, 3'd5, 17'd99999,  1'b0, 1'b0, 17'd0},
            '{3'd5, 3'd6, 17'd1,      1'b0, 1'b0, 17'd0},
            '{3'd7, 3'd0, 17'd1,      1'b1, 1'b1, 17'd7},
            '{3'd0, 3'd6, 17'd100000, 1'b1, 1'b1, apsp_pkg::INF_DIST},
            '{3'd6, 3'd1, 17'd50000,  1'b0, 1'b0, 17'd0},
            '{3'd1, 3'd0, 17'd50000,  1'b1, 1'b0, 17'd0},
            '{3'd7, 3'd7, 17'd0,      1'b1, 1'b1, apsp_pkg::INF_DIST}
        };
        foreach (rows[i]) begin
            r = rows[i];
            send_edge(r.from_v, r.to_v, r.weight, r.last);
            if (r.check_exp) begin
                // Entry (0,1) is the second result of the matrix.
                s_valid <= 1'b0;
                while (expected_dists.size() != 0) @(posedge aclk);
                if (dut_d01_seen != r.exp_d01) begin
                    $display("%0t: distance(0,1) expected %0d actual %0d",
                             $time, r.exp_d01, dut_d01_seen);
                    fail_count++;
                end
            end
        end
        drain_results();

        // Random phases across vertex counts and idling mixes.
        phase_idle = '{0, 81, 0, 13};
        phase_stall = '{0, 0, 81, 13};
        vc_list = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5};
        for (int p = 0; p < 6; p++) begin
            write_vertex_count(vc_list[p]);
            send_idle_pct = phase_idle[p % 4];
            recv_stall_pct = phase_stall[p % 4];
            for (int g = 0; g < 5; g++) begin
                send_random_graph($urandom_range(3, 10));
                if (g == 2) drain_results();
            end
            drain_results();
        end

        // Long receiver hold-off while graphs keep arriving.
        write_vertex_count(4'd8);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            begin
                for (int g = 0; g < 4; g++) send_random_graph(6);
            end
        join
        drain_results();

        if (fail_count == 0) begin
            $display("PASS all_pairs_shortest_path");
        end else begin
            $display("FAIL all_pairs_shortest_path");
        end
        $finish;
    end
endmodule
